>>> rtl/rnpr_pkg.sv
// ----------------------------------------------------------------------------
// rnpr_pkg: shared types and constants of the next-PC resolver
// Request and response payloads, the inter-stage records and the RISC-V
// opcode and branch condition codes used by the pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

package rnpr_pkg;

   localparam int XLEN = 64;

   // 32-bit major opcodes
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_BRANCH = 7'h63;

   // Compressed quadrants
   localparam logic [1:0] QUAD_C1   = 2'b01;
   localparam logic [1:0] QUAD_C2   = 2'b10;
   localparam logic [1:0] QUAD_FULL = 2'b11;

   // Compressed funct3 / funct4 codes
   localparam logic [2:0] CF3_J    = 3'h5;
   localparam logic [2:0] CF3_BEQZ = 3'h6;
   localparam logic [2:0] CF3_BNEZ = 3'h7;
   localparam logic [3:0] CF4_JR   = 4'h8;
   localparam logic [3:0] CF4_JALR = 4'h9;

   // Link register of C.JALR
   localparam logic [4:0] REG_RA = 5'h1;

   // Branch funct3 codes
   localparam logic [2:0] BR_BEQ  = 3'h0;
   localparam logic [2:0] BR_BNE  = 3'h1;
   localparam logic [2:0] BR_RSV2 = 3'h2;
   localparam logic [2:0] BR_RSV3 = 3'h3;
   localparam logic [2:0] BR_BLT  = 3'h4;
   localparam logic [2:0] BR_BGE  = 3'h5;
   localparam logic [2:0] BR_BLTU = 3'h6;
   localparam logic [2:0] BR_BGEU = 3'h7;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_JUMP,
      KIND_BRANCH,
      KIND_ILLEGAL
   } kind_type;

   typedef struct packed {
      logic              func;
      logic [31:0]       instruction;
      logic [XLEN-1:0]   pc;
      logic signed [XLEN-1:0] rs1_value;
      logic signed [XLEN-1:0] rs2_value;
      logic              update_link;
   } req_type;

   typedef struct packed {
      logic              is_transfer;
      logic              illegal_branch;
      logic [XLEN-1:0]   next_pc;
      logic              link_write;
      logic [4:0]        link_reg;
      logic [XLEN-1:0]   link_value;
   } rsp_type;

   // Decode stage record
   typedef struct packed {
      kind_type          kind;
      logic [2:0]        cond;
      logic              predict;
      logic              clear_lsb;
      logic              compressed;
      logic              link_write;
      logic [4:0]        link_reg;
      logic [XLEN-1:0]   base;
      logic [XLEN-1:0]   imm;
      logic [XLEN-1:0]   pc;
      logic [XLEN-1:0]   op_a;
      logic [XLEN-1:0]   op_b;
   } dec_type;

   // Execute stage record
   typedef struct packed {
      kind_type          kind;
      logic              redirect;
      logic              link_write;
      logic [4:0]        link_reg;
      logic [XLEN-1:0]   target;
      logic [XLEN-1:0]   seq_pc;
      logic [XLEN-1:0]   pc;
   } exe_type;

endpackage

`default_nettype wire

>>> rtl/rnpr_decode.sv
// ----------------------------------------------------------------------------
// rnpr_decode: instruction decode stage
// Classifies the instruction word, extracts its immediate, picks the target
// base and the compare operands, and decides the link register write.
// ----------------------------------------------------------------------------
`default_nettype none

module rnpr_decode
   import rnpr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_stall,
   input  wire req_type in_data,
   output logic         out_valid,
   input  wire logic    out_stall,
   output dec_type      out_data
);

   logic    valid_ff, valid_in;
   dec_type data_ff, data_in;

   logic [31:0] w;
   logic [1:0]  quad;
   logic [2:0]  cf3;
   logic [3:0]  cf4;
   logic [4:0]  rd, r2;
   logic [2:0]  f3;

   assign w    = in_data.instruction;
   assign quad = w[1:0];
   assign cf3  = w[15:13];
   assign cf4  = w[15:12];
   assign rd   = w[11:7];
   assign r2   = w[6:2];
   assign f3   = w[14:12];

   always_comb begin
      data_in            = '0;
      data_in.kind       = KIND_NONE;
      data_in.predict    = in_data.func;
      data_in.compressed = (quad != QUAD_FULL);
      data_in.pc         = in_data.pc;
      data_in.base       = in_data.pc;
      data_in.op_a       = in_data.rs1_value;
      data_in.op_b       = in_data.rs2_value;
      case (quad)
         QUAD_C1: begin
            if (cf3 == CF3_J) begin
               data_in.kind = KIND_JUMP;
               data_in.imm  = {{(XLEN-12){w[12]}}, w[12], w[8], w[10:9], w[6], w[7],
                               w[2], w[11], w[5:3], 1'b0};
            end else if (cf3 == CF3_BEQZ || cf3 == CF3_BNEZ) begin
               data_in.kind = KIND_BRANCH;
               data_in.cond = (cf3 == CF3_BEQZ) ? BR_BEQ : BR_BNE;
               data_in.op_b = '0;
               data_in.imm  = {{(XLEN-9){w[12]}}, w[12], w[6:5], w[2], w[11:10],
                               w[4:3], 1'b0};
            end
         end
         QUAD_C2: begin
            if ((cf4 == CF4_JR || cf4 == CF4_JALR) && rd != '0 && r2 == '0) begin
               data_in.kind      = KIND_JUMP;
               data_in.base      = in_data.rs1_value;
               data_in.clear_lsb = 1'b1;
               if (cf4 == CF4_JALR && in_data.update_link) begin
                  data_in.link_write = 1'b1;
                  data_in.link_reg   = REG_RA;
               end
            end
         end
         QUAD_FULL: begin
            unique case (w[6:0])
               OPC_JAL: begin
                  data_in.kind       = KIND_JUMP;
                  data_in.imm        = {{(XLEN-21){w[31]}}, w[31], w[19:12], w[20],
                                        w[30:21], 1'b0};
                  data_in.link_write = in_data.update_link && rd != '0;
                  data_in.link_reg   = data_in.link_write ? rd : '0;
               end
               OPC_JALR: begin
                  data_in.kind       = KIND_JUMP;
                  data_in.base       = in_data.rs1_value;
                  data_in.clear_lsb  = 1'b1;
                  data_in.imm        = {{(XLEN-12){w[31]}}, w[31:20]};
                  data_in.link_write = in_data.update_link && rd != '0;
                  data_in.link_reg   = data_in.link_write ? rd : '0;
               end
               OPC_BRANCH: begin
                  data_in.cond = f3;
                  data_in.imm  = {{(XLEN-13){w[31]}}, w[31], w[7], w[30:25], w[11:8],
                                  1'b0};
                  if (f3 == BR_RSV2 || f3 == BR_RSV3) begin
                     data_in.kind = KIND_ILLEGAL;
                  end else begin
                     data_in.kind = KIND_BRANCH;
                  end
               end
               default: data_in.kind = KIND_NONE;
            endcase
         end
         default: data_in.kind = KIND_NONE;
      endcase
   end

   assign in_stall = valid_ff && out_stall;
   assign valid_in = in_stall ? valid_ff : in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (!in_stall) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

>>> rtl/rnpr_execute.sv
// ----------------------------------------------------------------------------
// rnpr_execute: target, sequential address and branch condition stage
// Adds the immediate to the selected base, forms the fall-through address
// and evaluates the branch condition on the source operands.
// ----------------------------------------------------------------------------
`default_nettype none

module rnpr_execute
   import rnpr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_stall,
   input  wire dec_type in_data,
   output logic         out_valid,
   input  wire logic    out_stall,
   output exe_type      out_data
);

   logic    valid_ff, valid_in;
   exe_type data_ff, data_in;

   logic [XLEN-1:0] sum;
   logic            eq, lts, ltu, take;

   assign sum = in_data.base + in_data.imm;
   assign eq  = (in_data.op_a == in_data.op_b);
   assign lts = ($signed(in_data.op_a) < $signed(in_data.op_b));
   assign ltu = (in_data.op_a < in_data.op_b);

   always_comb begin
      case (in_data.cond)
         BR_BEQ:  take = eq;
         BR_BNE:  take = !eq;
         BR_BLT:  take = lts;
         BR_BGE:  take = !lts;
         BR_BLTU: take = ltu;
         BR_BGEU: take = !ltu;
         default: take = 1'b0;
      endcase
   end

   always_comb begin
      data_in            = '0;
      data_in.kind       = in_data.kind;
      data_in.redirect   = (in_data.kind == KIND_JUMP) ||
                           ((in_data.kind == KIND_BRANCH) && (in_data.predict || take));
      data_in.link_write = in_data.link_write;
      data_in.link_reg   = in_data.link_reg;
      data_in.target     = {sum[XLEN-1:1], sum[0] & !in_data.clear_lsb};
      data_in.seq_pc     = in_data.pc + (in_data.compressed ? XLEN'(2) : XLEN'(4));
      data_in.pc         = in_data.pc;
   end

   assign in_stall = valid_ff && out_stall;
   assign valid_in = in_stall ? valid_ff : in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (!in_stall) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

>>> rtl/rnpr_resolve.sv
// ----------------------------------------------------------------------------
// rnpr_resolve: next-PC selection and response register
// Chooses the next PC among target, fall-through and the instruction's own
// address, and builds the link write fields of the response.
// ----------------------------------------------------------------------------
`default_nettype none

module rnpr_resolve
   import rnpr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_stall,
   input  wire exe_type in_data,
   output logic         out_valid,
   input  wire logic    out_stall,
   output rsp_type      out_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   always_comb begin
      data_in                = '0;
      data_in.is_transfer    = (in_data.kind == KIND_JUMP) || (in_data.kind == KIND_BRANCH);
      data_in.illegal_branch = (in_data.kind == KIND_ILLEGAL);
      if (in_data.kind == KIND_ILLEGAL) begin
         data_in.next_pc = in_data.pc;
      end else if (in_data.redirect) begin
         data_in.next_pc = in_data.target;
      end else begin
         data_in.next_pc = in_data.seq_pc;
      end
      data_in.link_write = in_data.link_write;
      if (in_data.link_write) begin
         data_in.link_reg   = in_data.link_reg;
         data_in.link_value = in_data.seq_pc;
      end
   end

   assign in_stall = valid_ff && out_stall;
   assign valid_in = in_stall ? valid_ff : in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (!in_stall) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

>>> rtl/riscv_next_pc_resolver_core.sv
// ----------------------------------------------------------------------------
// riscv_next_pc_resolver_core: RV64 jump and branch next-PC resolver
// Decodes JAL, JALR, conditional branches and their compressed forms and
// reports the next PC and the implied link register write.
// ----------------------------------------------------------------------------
// Usage:
//   A request on req_* carries the instruction word, its PC, the two source
//   values, the resolve/predict mode and the link enable. Each request gives
//   exactly one response on rsp_*, in request order.
//   The block is a three-stage pipeline: decode, then target add and branch
//   compare, then next-PC selection into the response register. A new request
//   can be taken every cycle while req_stall is low; the 64-bit add and
//   compare of the middle stage set the clock period.
//   Each stage holds its contents while the stage behind it is full and
//   stalled, so a stall on rsp_stall passes combinationally back through the
//   full stages and reaches req_stall only once all three stages hold
//   requests. Nothing is dropped or repeated.
//   Synchronous reset empties the pipeline; the block keeps no other state.
// ----------------------------------------------------------------------------
`default_nettype none

module riscv_next_pc_resolver_core
   import rnpr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   logic    dec_valid, dec_stall;
   dec_type dec_data;
   logic    exe_valid, exe_stall;
   exe_type exe_data;

   rnpr_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_payload),
      .out_valid (dec_valid),
      .out_stall (dec_stall),
      .out_data  (dec_data)
   );

   rnpr_execute u_execute (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_stall  (dec_stall),
      .in_data   (dec_data),
      .out_valid (exe_valid),
      .out_stall (exe_stall),
      .out_data  (exe_data)
   );

   rnpr_resolve u_resolve (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (exe_valid),
      .in_stall  (exe_stall),
      .in_data   (exe_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_payload)
   );

endmodule

`default_nettype wire

>>> tb/tb_riscv_next_pc_resolver_core.sv
// ----------------------------------------------------------------------------
// tb_riscv_next_pc_resolver_core: self-checking bench for the next-PC resolver
// Drives jumps, branches, their compressed forms and other words through the
// request channel and predicts each response from the decoded instruction. Every
// response is compared field by field with the oldest prediction. The sender
// works in bursts with gaps and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------

module tb_riscv_next_pc_resolver_core
   import rnpr_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_REQUESTS = 1525;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned DRAIN_EVERY     = 400;
   localparam longint unsigned RUN_LIMIT_NS = 2_000_000;
   localparam logic [63:0] S_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] S_MIN = 64'h8000_0000_0000_0000;

   typedef enum int unsigned {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_LONG
   } stall_mode_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   riscv_next_pc_resolver_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Holds the predicted next-PC responses in request order.
   class next_pc_scoreboard;
      rsp_type     expected_q[$];
      int unsigned requests;
      int unsigned responses;
      int unsigned transfers;
      int unsigned link_writes;
      int unsigned illegals;
      int unsigned errors;

      function rsp_type resolve(req_type r);
         logic [31:0] w;
         logic [20:0] j_imm;
         logic [12:0] b_imm;
         logic [11:0] cj_imm;
         logic [8:0]  cb_imm;
         logic        taken;
         rsp_type     res;
         w = r.instruction;
         res = '0;
         res.next_pc = r.pc + ((w[1:0] == QUAD_FULL) ? 64'd4 : 64'd2);
         case (w[1:0])
            QUAD_C1: begin
               cj_imm = {w[12], w[8], w[10:9], w[6], w[7], w[2], w[11], w[5:3], 1'b0};
               cb_imm = {w[12], w[6:5], w[2], w[11:10], w[4:3], 1'b0};
               if (w[15:13] == CF3_J) begin
                  res.is_transfer = 1'b1;
                  res.next_pc = r.pc + {{52{cj_imm[11]}}, cj_imm};
               end else if (w[15:13] == CF3_BEQZ || w[15:13] == CF3_BNEZ) begin
                  taken = (w[15:13] == CF3_BEQZ) ? (r.rs1_value == 0) : (r.rs1_value != 0);
                  res.is_transfer = 1'b1;
                  if (r.func || taken)
                     res.next_pc = r.pc + {{55{cb_imm[8]}}, cb_imm};
               end
            end
            QUAD_C2: begin
               // C.JR and C.JALR need a nonzero rs1 and a zero rs2.
               if ((w[15:12] == CF4_JR || w[15:12] == CF4_JALR) &&
                   w[11:7] != 5'd0 && w[6:2] == 5'd0) begin
                  res.is_transfer = 1'b1;
                  res.next_pc = r.rs1_value & ~64'd1;
                  if (w[15:12] == CF4_JALR && r.update_link) begin
                     res.link_write = 1'b1;
                     res.link_reg   = REG_RA;
                     res.link_value = r.pc + 64'd2;
                  end
               end
            end
            QUAD_FULL: begin
               j_imm = {w[31], w[19:12], w[20], w[30:21], 1'b0};
               b_imm = {w[31], w[7], w[30:25], w[11:8], 1'b0};
               if (w[6:0] == OPC_JAL || w[6:0] == OPC_JALR) begin
                  res.is_transfer = 1'b1;
                  if (w[6:0] == OPC_JAL)
                     res.next_pc = r.pc + {{43{j_imm[20]}}, j_imm};
                  else
                     res.next_pc = (r.rs1_value + {{52{w[31]}}, w[31:20]}) & ~64'd1;
                  if (r.update_link && w[11:7] != 5'd0) begin
                     res.link_write = 1'b1;
                     res.link_reg   = w[11:7];
                     res.link_value = r.pc + 64'd4;
                  end
               end else if (w[6:0] == OPC_BRANCH) begin
                  taken = 1'b0;
                  case (w[14:12])
                     BR_BEQ:  taken = (r.rs1_value == r.rs2_value);
                     BR_BNE:  taken = (r.rs1_value != r.rs2_value);
                     BR_BLT:  taken = (r.rs1_value < r.rs2_value);
                     BR_BGE:  taken = (r.rs1_value >= r.rs2_value);
                     BR_BLTU: taken = ($unsigned(r.rs1_value) < $unsigned(r.rs2_value));
                     BR_BGEU: taken = ($unsigned(r.rs1_value) >= $unsigned(r.rs2_value));
                     default: res.illegal_branch = 1'b1;
                  endcase
                  if (res.illegal_branch) begin
                     res.next_pc = r.pc;
                  end else begin
                     res.is_transfer = 1'b1;
                     if (r.func || taken)
                        res.next_pc = r.pc + {{51{b_imm[12]}}, b_imm};
                  end
               end
            end
            default: ;
         endcase
         return res;
      endfunction

      function void note_request(req_type r);
         expected_q.push_back(resolve(r));
         requests++;
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         responses++;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: response with no request outstanding: %h", $realtime, got);
            return;
         end
         want = expected_q.pop_front();
         transfers   += want.is_transfer;
         link_writes += want.link_write;
         illegals    += want.illegal_branch;
         if (got.is_transfer !== want.is_transfer || got.illegal_branch !== want.illegal_branch ||
             got.next_pc !== want.next_pc || got.link_write !== want.link_write ||
             got.link_reg !== want.link_reg || got.link_value !== want.link_value) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t: response %0d mismatch", $realtime, responses);
               $display("   expected xfer=%b ill=%b npc=%h lw=%b lreg=%0d lval=%h",
                        want.is_transfer, want.illegal_branch, want.next_pc,
                        want.link_write, want.link_reg, want.link_value);
               $display("   actual   xfer=%b ill=%b npc=%h lw=%b lreg=%0d lval=%h",
                        got.is_transfer, got.illegal_branch, got.next_pc,
                        got.link_write, got.link_reg, got.link_value);
            end
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   next_pc_scoreboard board;

   // ------------------------------------------------------------------
   // Instruction encoders; register fields that do not matter are random.
   // ------------------------------------------------------------------
   function automatic logic [31:0] enc_jal(logic [4:0] rd, logic [20:0] imm);
      return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
   endfunction

   function automatic logic [31:0] enc_jalr(logic [4:0] rd, logic [2:0] f3, logic [11:0] imm);
      return {imm, 5'($urandom), f3, rd, OPC_JALR};
   endfunction

   function automatic logic [31:0] enc_branch(logic [2:0] f3, logic [12:0] imm);
      return {imm[12], imm[10:5], 5'($urandom), 5'($urandom), f3, imm[4:1], imm[11],
              OPC_BRANCH};
   endfunction

   function automatic logic [31:0] enc_cj(logic [11:0] imm);
      return {16'($urandom), CF3_J, imm[11], imm[4], imm[9:8], imm[10], imm[6], imm[7],
              imm[3:1], imm[5], QUAD_C1};
   endfunction

   function automatic logic [31:0] enc_cb(logic [2:0] f3, logic [8:0] imm);
      return {16'($urandom), f3, imm[8], imm[4:3], 3'($urandom), imm[7:6], imm[2:1], imm[5],
              QUAD_C1};
   endfunction

   function automatic logic [31:0] enc_cr(logic [3:0] f4, logic [4:0] r1, logic [4:0] r2);
      return {16'($urandom), f4, r1, r2, QUAD_C2};
   endfunction

   function automatic req_type make_request(logic f, logic [31:0] w, logic [63:0] pc,
                                            logic [63:0] a, logic [63:0] b, logic upd);
      req_type r;
      r.func        = f;
      r.instruction = w;
      r.pc          = pc;
      r.rs1_value   = a;
      r.rs2_value   = b;
      r.update_link = upd;
      return r;
   endfunction

   // Favors the signed and unsigned extremes that separate the compares.
   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return S_MAX;
         3: return S_MIN;
         4: return 64'($urandom_range(0, 15));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_type random_request();
      req_type     r;
      logic [31:0] w;
      logic [4:0]  r1;
      logic [4:0]  r2;
      int unsigned pick;
      r = make_request(1'($urandom), 32'd0, pick_value(), pick_value(), 64'd0,
                       $urandom_range(0, 3) != 0);
      r.rs2_value = ($urandom_range(0, 3) == 0) ? r.rs1_value : pick_value();
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
         w = enc_jal(5'($urandom), 21'($urandom));
      end else if (pick < 28) begin
         w = enc_jalr(5'($urandom), 3'($urandom), 12'($urandom));
      end else if (pick < 56) begin
         w = enc_branch(3'($urandom), 13'($urandom));
      end else if (pick < 64) begin
         w = enc_cj(12'($urandom));
      end else if (pick < 76) begin
         w = enc_cb($urandom_range(0, 1) ? CF3_BEQZ : CF3_BNEZ, 9'($urandom));
         if ($urandom_range(0, 4) < 2)
            r.rs1_value = '0;
      end else if (pick < 88) begin
         r1 = ($urandom_range(0, 9) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
         r2 = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(1, 31)) : 5'd0;
         w = enc_cr($urandom_range(0, 1) ? CF4_JR : CF4_JALR, r1, r2);
      end else begin
         w = $urandom;
      end
      r.instruction = w;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------
   task automatic send_request(input req_type r);
      @(negedge clock);
      req_payload <= r;
      req_valid   <= 1'b1;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   task automatic hold_sender(input int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic wait_all_responses();
      hold_sender(1);
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   task automatic run_directed();
      // JAL at the immediate extremes, with and without a link write.
      send_request(make_request(1'b0, enc_jal(5'd1, 21'h0FFFFE), '1, '0, '0, 1'b1));
      send_request(make_request(1'b1, enc_jal(5'd0, 21'h100000), '0, S_MAX, S_MIN, 1'b1));
      send_request(make_request(1'b0, enc_jal(5'd31, 21'h000002), S_MAX, '1, '1, 1'b0));
      // JALR clears bit 0 of the target and ignores its funct3 bits.
      send_request(make_request(1'b0, enc_jalr(5'd5, 3'd0, 12'hFFF), 64'h1000, '1, '0, 1'b1));
      send_request(make_request(1'b1, enc_jalr(5'd31, 3'd7, 12'h7FF), '1, S_MAX, '0, 1'b1));
      // Every branch code with operands whose signed and unsigned orders differ.
      for (int k = 0; k < 8; k++)
         send_request(make_request(1'b0, enc_branch(3'(k), 13'h0FFE), 64'h4000, '1, 64'd1,
                                   1'b1));
      send_request(make_request(1'b0, enc_branch(BR_BEQ, 13'h1000), '0, S_MIN, S_MIN, 1'b1));
      send_request(make_request(1'b1, enc_branch(BR_BNE, 13'h1000), 64'h10, 64'd7, 64'd7,
                                1'b1));
      send_request(make_request(1'b0, enc_cj(12'h800), 64'h2, '0, '0, 1'b1));
      send_request(make_request(1'b0, enc_cb(CF3_BEQZ, 9'h100), 64'h100, '0, '1, 1'b1));
      send_request(make_request(1'b0, enc_cb(CF3_BNEZ, 9'h0FE), 64'h100, '0, '1, 1'b1));
      send_request(make_request(1'b1, enc_cb(CF3_BNEZ, 9'h0FE), '1, '0, '0, 1'b1));
      send_request(make_request(1'b0, enc_cr(CF4_JR, 5'd31, 5'd0), 64'h80, '1, '0, 1'b1));
      send_request(make_request(1'b0, enc_cr(CF4_JALR, 5'd1, 5'd0), '1, 64'h1235, '0, 1'b1));
      // Not transfers: C.JR with rs1 zero, C.JALR with rs2 set, C.ADDIW and quadrant 0.
      send_request(make_request(1'b0, enc_cr(CF4_JR, 5'd0, 5'd0), 64'h40, '1, '0, 1'b1));
      send_request(make_request(1'b0, enc_cr(CF4_JALR, 5'd2, 5'd3), 64'h40, '1, '0, 1'b1));
      send_request(make_request(1'b0, {16'hFFFF, 3'b001, 11'h7FF, QUAD_C1}, '1, '0, '0, 1'b1));
      send_request(make_request(1'b1, 32'hFFFF_FFFC, '1, '1, '1, 1'b1));
      send_request(make_request(1'b0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE, '1, '1, 1'b1));
   endtask

   // ------------------------------------------------------------------
   // Clock, response stall pattern, monitor and run limit
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      stall_mode_type mode;
      int unsigned    span;
      rsp_stall = 1'b0;
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         span = $urandom_range(32, 256);
         for (int unsigned k = 0; k < span; k++) begin
            @(negedge clock);
            case (mode)
               STALL_NONE:     rsp_stall <= 1'b0;
               STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 2) == 0);
               STALL_PERIODIC: rsp_stall <= (k % 4 == 3);
               default:        rsp_stall <= (k % 24 < 16);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            board.note_request(req_payload);
         if (rsp_valid && !rsp_stall)
            board.check_response(rsp_payload);
      end
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("Run limit reached with %0d responses outstanding.", board.pending());
      $display("tb_riscv_next_pc_resolver_core failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int unsigned burst_left;
      board       = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      wait_all_responses();

      burst_left = 0;
      for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % DRAIN_EVERY == DRAIN_EVERY - 1) begin
            wait_all_responses();
         end else if (burst_left == 0) begin
            // Some bursts follow each other back to back.
            if ($urandom_range(0, 3) != 0)
               hold_sender($urandom_range(1, 12));
            burst_left = $urandom_range(1, 48);
         end
         send_request(random_request());
         if (burst_left != 0)
            burst_left--;
      end

      wait_all_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Checked %0d responses for %0d requests: %0d transfers, %0d link writes,",
               board.responses, board.requests, board.transfers, board.link_writes);
      $display("%0d reserved branch codes, %0d errors, under bursty input and varied stalls.",
               board.illegals, board.errors);
      if (board.errors == 0 && board.pending() == 0)
         $display("tb_riscv_next_pc_resolver_core passed");
      else
         $display("tb_riscv_next_pc_resolver_core failed");
      $finish;
   end

endmodule

>>> files.f
rtl/rnpr_pkg.sv
rtl/rnpr_decode.sv
rtl/rnpr_execute.sv
rtl/rnpr_resolve.sv
rtl/riscv_next_pc_resolver_core.sv
tb/tb_riscv_next_pc_resolver_core.sv
